/* rtl/core/slr_pkg.sv */
// Shared constants, types and register codes for the stream literal replacer.
`default_nettype none
package slr_pkg;

	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;
	localparam int FIELD_BYTES     = 8;
	localparam int PLEN_CAP  = (MAX_PATTERN < FIELD_BYTES) ? MAX_PATTERN : FIELD_BYTES;
	localparam int RLEN_CAP  = (MAX_REPLACEMENT < FIELD_BYTES) ? MAX_REPLACEMENT : FIELD_BYTES;
	localparam int NUM_CELLS = MAX_PATTERN - 1;
	localparam int SEQ_N     = (PLEN_CAP > RLEN_CAP) ? PLEN_CAP : RLEN_CAP;

	localparam int LEN_W      = 4;
	localparam int FILL_W     = $clog2(MAX_PATTERN);
	localparam int AGE_W      = $clog2(MAX_PATTERN);
	localparam int BYTE_IDX_W = $clog2(FIELD_BYTES);
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

	typedef logic [FIELD_BYTES-1:0][7:0] field_bytes_t;
	typedef logic [SEQ_N-1:0][7:0]       seq_t;

	typedef struct packed {
		field_bytes_t     pattern;
		logic [LEN_W-1:0] plen;
		field_bytes_t     repl;
		logic [LEN_W-1:0] rlen;
	} cfg_t;

	typedef struct packed {
		seq_t             seq;
		logic [LEN_W-1:0] cnt;
		logic             has;
		logic             fin;
	} job_t;

endpackage
`default_nettype wire

/* rtl/core/slr_cell.sv */
// One window cell: holds a byte, passes it on, and extends the match chain.
`default_nettype none
module slr_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] byte_in,
	input  logic [7:0] pat_byte,
	input  logic       active,
	input  logic       match_in,
	output logic [7:0] byte_q,
	output logic       match_out
);
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	// Cells beyond the current pattern length do not take part in the compare.
	assign match_out = match_in & (!active | (byte_q == pat_byte));
endmodule
`default_nettype wire

/* rtl/core/slr_window.sv */
// Window of past bytes as a row of cells, fill count, and result job builder.
`default_nettype none
module slr_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          final_byte,
	input  logic          clear_fill,
	input  slr_pkg::cfg_t cfg,
	output slr_pkg::job_t job
);
	import slr_pkg::*;

	logic [FILL_W-1:0]     fill_q;
	logic [NUM_CELLS-1:0][7:0] cell_byte;
	logic [NUM_CELLS-1:0][7:0] cell_pat;
	logic [NUM_CELLS-1:0][7:0] cell_in;
	logic [NUM_CELLS-1:0]  cell_active;
	logic [NUM_CELLS:0]    chain;
	logic [NUM_CELLS-1:0][LEN_W-1:0] cell_pidx;
	logic [MAX_PATTERN-1:0][7:0] ages;

	logic [LEN_W-1:0] plen_m1;
	logic [LEN_W-1:0] n0;
	logic [LEN_W-1:0] n1;
	logic [LEN_W-1:0] start;
	logic [LEN_W-1:0] cnt;
	logic             full;
	logic             match;
	logic             use_repl;
	logic             has;

	assign plen_m1 = cfg.plen - LEN_W'(1);

	// Cell k holds the byte k+1 places before the incoming one.
	always_comb begin
		for (int k = 0; k < NUM_CELLS; k++) begin
			cell_active[k] = (LEN_W'(k + 1) <= plen_m1);
			cell_pidx[k]   = plen_m1 - LEN_W'(k + 1);
			cell_pat[k]    = cfg.pattern[cell_pidx[k][BYTE_IDX_W-1:0]];
			cell_in[k]     = (k == 0) ? data_byte : cell_byte[(k == 0) ? 0 : k - 1];
		end
	end

	assign chain[0] = (data_byte == cfg.pattern[plen_m1[BYTE_IDX_W-1:0]]);

	genvar g;
	generate
		for (g = 0; g < NUM_CELLS; g++) begin : g_cell
			slr_cell u_cell (
				.clk      (clk),
				.shift    (accept),
				.byte_in  (cell_in[g]),
				.pat_byte (cell_pat[g]),
				.active   (cell_active[g]),
				.match_in (chain[g]),
				.byte_q   (cell_byte[g]),
				.match_out(chain[g+1])
			);
		end
	endgenerate

	always_comb begin
		ages[0] = data_byte;
		for (int k = 0; k < NUM_CELLS; k++) begin
			ages[k+1] = cell_byte[k];
		end
	end

	always_comb begin
		n0 = (LEN_W'(fill_q) > plen_m1) ? plen_m1 : LEN_W'(fill_q);
		n1 = n0 + LEN_W'(1);
		full = (n1 == cfg.plen);
		match = full & chain[NUM_CELLS];
		use_repl = match;
		start = n0;
		cnt = '0;
		if (match) begin
			cnt = cfg.rlen;
		end else if (full) begin
			start = plen_m1;
			cnt = final_byte ? cfg.plen : LEN_W'(1);
		end else begin
			cnt = final_byte ? n1 : '0;
		end
		has = 1'b1;
		if (final_byte && (cnt == '0)) begin
			cnt = LEN_W'(1);
			has = 1'b0;
		end
	end

	// Results are listed oldest first: replacement bytes, or window bytes by age.
	always_comb begin
		for (int j = 0; j < SEQ_N; j++) begin
			if (!has) begin
				job.seq[j] = 8'h00;
			end else if (use_repl) begin
				job.seq[j] = cfg.repl[j];
			end else if (LEN_W'(j) <= start) begin
				job.seq[j] = ages[start[AGE_W-1:0] - AGE_W'(j)];
			end else begin
				job.seq[j] = 8'h00;
			end
		end
		job.cnt = cnt;
		job.has = has;
		job.fin = final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear_fill) begin
			fill_q <= '0;
		end else if (accept) begin
			if (final_byte || match) begin
				fill_q <= '0;
			end else if (full) begin
				fill_q <= plen_m1[FILL_W-1:0];
			end else begin
				fill_q <= n1[FILL_W-1:0];
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/core/slr_emitter.sv */
// Output stage: holds the result bytes of one input byte and hands them out in order.
`default_nettype none
module slr_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  slr_pkg::job_t job,
	output logic          take_ok,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          has_byte,
	output logic          run_last,
	output logic          stream_end
);
	import slr_pkg::*;

	logic [LEN_W-1:0] rem_q;
	seq_t             seq_q;
	logic             has_q;
	logic             fin_q;
	logic             load;
	logic             emit;

	assign out_valid = (rem_q != '0);
	assign emit      = out_valid & out_ready;
	assign load      = accept & (job.cnt != '0);
	// A new job may enter while the last result of the current one leaves.
	assign take_ok   = (rem_q == '0) || ((rem_q == LEN_W'(1)) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= job.cnt;
		end else if (emit) begin
			rem_q <= rem_q - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seq_q <= job.seq;
			has_q <= job.has;
			fin_q <= job.fin;
		end else if (emit) begin
			seq_q <= seq_t'(seq_q >> 8);
		end
	end

	assign out_byte   = seq_q[0];
	assign has_byte   = has_q;
	assign run_last   = (rem_q == LEN_W'(1));
	assign stream_end = run_last & fin_q;
endmodule
`default_nettype wire

/* rtl/core/stream_literal_replace.sv */
// Latency: the first result of a byte is shown the cycle after its transaction.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output is ready; a byte with several results (replacement or end flush, up to 8) holds
// the output stage, and the input waits until its last result is being taken.
// Reset: pattern_length returns to 1, the other registers to 0, window and output empty.
`default_nettype none
module stream_literal_replace (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] data_byte
	input  logic                             s_tlast,  // final_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [slr_pkg::OUT_DATA_W-1:0]   m_tdata,  // [7:0] out_byte, [8] run_last
	output logic                             m_tuser,  // has_byte
	output logic                             m_tlast,  // stream_end
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [slr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                      cfg_data
);
	import slr_pkg::*;

	cfg_t             cfg_q;
	job_t             job;
	logic             accept;
	logic             cfg_write;
	logic             clear_fill;
	logic [LEN_W-1:0] plen_raw;
	logic [LEN_W-1:0] rlen_raw;
	logic [LEN_W-1:0] plen_eff;
	logic [LEN_W-1:0] rlen_eff;
	logic [7:0]       out_byte;
	logic             run_last;

	assign cfg_ready  = 1'b1;
	assign cfg_write  = cfg_valid & cfg_ready;
	assign clear_fill = cfg_write & (cfg_index == REG_PATTERN_LENGTH);
	assign accept     = s_tvalid & s_tready;

	assign plen_raw = cfg_data[LEN_W-1:0];
	assign rlen_raw = cfg_data[LEN_W-1:0];

	always_comb begin
		if (plen_raw == '0) begin
			plen_eff = LEN_W'(1);
		end else if (plen_raw > LEN_W'(PLEN_CAP)) begin
			plen_eff = LEN_W'(PLEN_CAP);
		end else begin
			plen_eff = plen_raw;
		end
		rlen_eff = (rlen_raw > LEN_W'(RLEN_CAP)) ? LEN_W'(RLEN_CAP) : rlen_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.plen    <= LEN_W'(1);
			cfg_q.repl    <= '0;
			cfg_q.rlen    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PATTERN_BYTES:      cfg_q.pattern <= field_bytes_t'(cfg_data);
				REG_PATTERN_LENGTH:     cfg_q.plen    <= plen_eff;
				REG_REPLACEMENT_BYTES:  cfg_q.repl    <= field_bytes_t'(cfg_data);
				REG_REPLACEMENT_LENGTH: cfg_q.rlen    <= rlen_eff;
				default: ;
			endcase
		end
	end

	slr_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_tdata),
		.final_byte(s_tlast),
		.clear_fill(clear_fill),
		.cfg       (cfg_q),
		.job       (job)
	);

	slr_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.job       (job),
		.take_ok   (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.has_byte  (m_tuser),
		.run_last  (run_last),
		.stream_end(m_tlast)
	);

	assign m_tdata = {(OUT_DATA_W - 9)'(0), run_last, out_byte};
endmodule
`default_nettype wire

/* rtl/core/slr_checker.sv */
// Port-level checks for the stream literal replacer, bound to the top level.
`default_nettype none
module slr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [slr_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tuser,
	input logic                           m_tlast
);
	// The end of a text is always also the last result of its byte.
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[8])
		else $error("stream end without run_last");

	// A bare end marker carries a zero byte and closes both the run and the text.
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[8] && (m_tdata[7:0] == 8'h00))
		else $error("malformed bare end marker");

	// The input only stalls while results are waiting at the output.
	a_stall_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transaction dropped while stalled");
endmodule

bind stream_literal_replace slr_checker u_slr_checker (.*);
`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the streaming literal find-and-replace block.
`default_nettype none
module testbench;
	import slr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} text_byte_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       run_last;
		logic       stream_end;
	} text_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'h00;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_BYTES;
	logic [63:0]           cfg_data = 64'h0;

	stream_literal_replace u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the configuration and the match window.
	logic [63:0] cfg_pattern = 64'h0;
	logic [3:0]  cfg_plen = 4'd1;
	logic [63:0] cfg_repl = 64'h0;
	logic [3:0]  cfg_rlen = 4'd0;
	logic [7:0]  win_store [8] = '{default: 8'h00};
	int          win_fill = 0;

	text_byte_t  byte_pending [$];
	text_out_t   text_expected [$];

	int  cycle_count = 0;
	int  mismatches = 0;
	int  bytes_queued = 0;
	int  bytes_accepted = 0;
	int  bytes_emitted = 0;
	int  texts_ended = 0;
	int  matches_replaced = 0;
	int  send_odds = 0;
	int  recv_odds = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  recv_hold = 0;
	bit  hold_request = 1'b0;
	bit  byte_taken = 1'b0;

	function automatic int eff_plen();
		int n;
		n = cfg_plen;
		if (n == 0) n = 1;
		if (n > PLEN_CAP) n = PLEN_CAP;
		return n;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH (cycle %0d): %s", cycle_count, msg);
	endtask

	// Works out the output transactions caused by one accepted input byte.
	task automatic predict_replace(input logic [7:0] b, input logic fin);
		logic [7:0] win [8];
		text_out_t  outs [$];
		int         plen;
		int         rlen;
		int         n;
		logic       hit;
		plen = eff_plen();
		rlen = cfg_rlen;
		if (rlen > RLEN_CAP) rlen = RLEN_CAP;
		n = (win_fill > plen - 1) ? plen - 1 : win_fill;
		win = win_store;
		win[n] = b;
		n++;
		if (n == plen) begin
			hit = 1'b1;
			for (int i = 0; i < plen; i++)
				if (win[i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
			if (hit) begin
				for (int i = 0; i < rlen; i++)
					outs.push_back('{cfg_repl[8*i +: 8], 1'b1, 1'b0, 1'b0});
				n = 0;
				matches_replaced++;
			end else begin
				outs.push_back('{win[0], 1'b1, 1'b0, 1'b0});
				for (int i = 1; i < plen; i++) win[i-1] = win[i];
				n = plen - 1;
			end
		end
		if (fin) begin
			for (int i = 0; i < n; i++)
				outs.push_back('{win[i], 1'b1, 1'b0, 1'b0});
			// A text that ends with nothing left to send still gets an end marker.
			if (outs.size() == 0)
				outs.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
			outs[outs.size()-1].stream_end = 1'b1;
			n = 0;
			foreach (win[i]) win[i] = 8'h00;
			texts_ended++;
		end
		win_store = win;
		win_fill = n;
		if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
		foreach (outs[i]) text_expected.push_back(outs[i]);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, text_expected.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Sampling at the rising edge: output checks and input prediction.
	always @(posedge clk) begin
		text_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bytes_emitted++;
			if (text_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected output transaction, byte %02h",
					m_tdata[7:0]));
			end else begin
				want = text_expected.pop_front();
				if (m_tdata[7:0] !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						m_tdata[7:0], want.data));
				if (m_tuser !== want.has)
					report_mismatch($sformatf("has_byte %b, expected %b", m_tuser, want.has));
				if (m_tdata[8] !== want.run_last)
					report_mismatch($sformatf("run_last %b, expected %b",
						m_tdata[8], want.run_last));
				if (m_tlast !== want.stream_end)
					report_mismatch($sformatf("stream_end %b, expected %b",
						m_tlast, want.stream_end));
				if (m_tdata[OUT_DATA_W-1:9] !== '0)
					report_mismatch($sformatf("tdata padding %h not zero", m_tdata));
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			bytes_accepted++;
			predict_replace(s_tdata, s_tlast);
			byte_taken = 1'b1;
		end
	end

	// Input driver, fed from the pending queue, with random idle bursts.
	always @(negedge clk) begin
		text_byte_t item;
		if (!s_tvalid || byte_taken) begin
			byte_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (byte_pending.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if ($urandom_range(0, 99) < send_odds) begin
				send_gap = $urandom_range(1, 18) - 1;
				s_tvalid <= 1'b0;
			end else begin
				item = byte_pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= item.data;
				s_tlast  <= item.fin;
			end
		end
	end

	// Output back-pressure: random bursts plus an occasional long hold.
	always @(negedge clk) begin
		if (hold_request) begin
			recv_hold = 250;
			hold_request = 1'b0;
		end
		if (recv_hold > 0) begin
			recv_hold--;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < recv_odds) begin
			recv_gap = $urandom_range(1, 18) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fin);
		byte_pending.push_back('{b, fin});
		bytes_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PATTERN_BYTES: cfg_pattern = value;
			REG_PATTERN_LENGTH: begin
				// Rewriting the length throws away whatever the window held.
				cfg_plen = value[3:0];
				win_fill = 0;
			end
			REG_REPLACEMENT_BYTES: cfg_repl = value;
			REG_REPLACEMENT_LENGTH: cfg_rlen = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_replace(input logic [63:0] pat, input logic [3:0] plen,
			input logic [63:0] rep, input logic [3:0] rlen);
		write_reg(REG_PATTERN_BYTES, pat);
		write_reg(REG_PATTERN_LENGTH, {60'h0, plen});
		write_reg(REG_REPLACEMENT_BYTES, rep);
		write_reg(REG_REPLACEMENT_LENGTH, {60'h0, rlen});
	endtask

	// Waits until the stream is idle and all results are in.
	task automatic wait_drained();
		do @(posedge clk);
		while (byte_pending.size() != 0 || s_tvalid || text_expected.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// One text: mostly whole or partial copies of the pattern mixed with noise.
	task automatic queue_text(input int chunks, input bit terminate);
		text_byte_t text [$];
		int         plen;
		int         pick;
		int         cut;
		plen = eff_plen();
		for (int c = 0; c < chunks; c++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				for (int i = 0; i < plen; i++) text.push_back('{cfg_pattern[8*i +: 8], 1'b0});
			end else if (pick < 6) begin
				cut = $urandom_range(1, plen);
				for (int i = 0; i < cut; i++) text.push_back('{cfg_pattern[8*i +: 8], 1'b0});
			end else if (pick < 8) begin
				cut = $urandom_range(0, plen - 1);
				text.push_back('{cfg_pattern[8*cut +: 8], 1'b0});
			end else begin
				text.push_back('{8'($urandom_range(0, 255)), 1'b0});
			end
		end
		if (terminate) text[text.size()-1].fin = 1'b1;
		foreach (text[i]) push_byte(text[i].data, text[i].fin);
	endtask

	initial begin
		int          plen;
		int          rlen;
		int          target;
		logic [63:0] pat;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_odds = 10;
		recv_odds = 10;

		// Settings after reset: single zero byte pattern deleted, then an empty end.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		wait_drained();

		// Three-byte pattern, two-byte replacement, tail flushed at the end.
		set_replace(64'h636261, 4'd3, 64'h5958, 4'd2);
		push_byte(8'h61, 1'b0);
		push_byte(8'h62, 1'b0);
		push_byte(8'h63, 1'b0);
		push_byte(8'h61, 1'b0);
		push_byte(8'h62, 1'b0);
		push_byte(8'h63, 1'b0);
		push_byte(8'h61, 1'b0);
		push_byte(8'h62, 1'b1);
		wait_drained();

		// Longest pattern and longest replacement.
		set_replace(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF, 4'd8);
		for (int i = 0; i < 8; i++) push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		wait_drained();

		// Zero pattern length acts as one, oversized replacement length saturates.
		set_replace(64'h41, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		push_byte(8'h41, 1'b0);
		push_byte(8'h41, 1'b1);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin plen = 1;  rlen = 0;  end
				1: begin plen = 8;  rlen = 8;  end
				2: begin plen = 3;  rlen = 2;  end
				3: begin plen = 15; rlen = 9;  end
				4: begin plen = 2;  rlen = 1;  end
				5: begin plen = 0;  rlen = 15; end
				6: begin plen = 5;  rlen = 3;  end
				default: begin plen = 8; rlen = 1; end
			endcase
			pat = {$urandom, $urandom};
			// Repeated-byte pattern exercises overlapping candidates.
			if (p == 2) pat = {8{8'($urandom_range(0, 255))}};
			set_replace(pat, 4'(plen), {$urandom, $urandom}, 4'(rlen));
			send_odds = (p == 7) ? 0 : $urandom_range(0, 15);
			recv_odds = (p == 7) ? 0 : $urandom_range(0, 15);
			// Long output hold while input keeps coming, so the block backs up.
			if (p == 1) hold_request = 1'b1;
			target = bytes_queued + 12;
			while (bytes_queued < target)
				queue_text($urandom_range(1, 6), $urandom_range(0, 3) != 0);
			wait_drained();
		end

		$display("Run covered %0d input bytes in %0d ended texts, %0d matches replaced,",
			bytes_accepted, texts_ended, matches_replaced);
		$display("and %0d output transactions over 12 register settings.", bytes_emitted);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/slr_pkg.sv
rtl/core/slr_cell.sv
rtl/core/slr_window.sv
rtl/core/slr_emitter.sv
rtl/core/stream_literal_replace.sv
rtl/core/slr_checker.sv
bench/testbench.sv
